@@ rtl/rvc_pkg.sv @@
// ----------------------------------------------------------------------------
// rvc_pkg
// types and codes shared by the rv64i integer core and its execute stage
// ----------------------------------------------------------------------------
package rvc_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned RegCount  = 32;
  localparam int unsigned RegAddrW  = 5;
  localparam logic [XLEN-1:0] DefaultResetAddress = 64'h0000_0000_8000_0000;

  localparam logic [1:0] ACT_INSTR       = 2'd0;
  localparam logic [1:0] ACT_FETCH_FAULT = 2'd1;
  localparam logic [1:0] ACT_LOAD_RSP    = 2'd2;
  localparam logic [1:0] ACT_STORE_RSP   = 2'd3;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [2:0] CAUSE_ILLEGAL    = 3'd0;
  localparam logic [2:0] CAUSE_MISALIGNED = 3'd1;
  localparam logic [2:0] CAUSE_BREAKPOINT = 3'd2;
  localparam logic [2:0] CAUSE_ECALL      = 3'd3;
  localparam logic [2:0] CAUSE_BUS_FAULT  = 3'd4;

  localparam logic [6:0] OP_LUI      = 7'h37;
  localparam logic [6:0] OP_AUIPC    = 7'h17;
  localparam logic [6:0] OP_MISC_MEM = 7'h0f;
  localparam logic [6:0] OP_JAL      = 7'h6f;
  localparam logic [6:0] OP_JALR     = 7'h67;
  localparam logic [6:0] OP_BRANCH   = 7'h63;
  localparam logic [6:0] OP_LOAD     = 7'h03;
  localparam logic [6:0] OP_STORE    = 7'h23;
  localparam logic [6:0] OP_IMM      = 7'h13;
  localparam logic [6:0] OP_IMM_W    = 7'h1b;
  localparam logic [6:0] OP_REG      = 7'h33;
  localparam logic [6:0] OP_REG_32   = 7'h3b;
  localparam logic [6:0] OP_SYSTEM   = 7'h73;

  localparam logic [6:0]  F7_ALT     = 7'h20;
  localparam logic [5:0]  F6_ALT     = 6'h10;
  localparam logic [11:0] IMM_ECALL  = 12'h000;
  localparam logic [11:0] IMM_EBREAK = 12'h001;

  typedef struct packed {
    logic [1:0]      action;
    logic [31:0]     instr_word;
    logic [XLEN-1:0] load_data;
    logic            bus_fault;
    logic [XLEN-1:0] fault_value;
  } in_t;

  typedef struct packed {
    logic [XLEN-1:0] pc_now;
    logic [1:0]      mem_op;
    logic [XLEN-1:0] mem_addr;
    logic [1:0]      mem_size;
    logic [XLEN-1:0] store_value;
    logic            retired;
    logic            trap;
    logic [2:0]      trap_cause;
    logic [XLEN-1:0] trap_value;
  } out_t;

  typedef struct packed {
    logic [1:0]          access;
    logic [RegAddrW-1:0] dest;
    logic [1:0]          size;
    logic                sgn;
  } pend_t;

  typedef struct packed {
    logic                we;
    logic [RegAddrW-1:0] addr;
    logic [XLEN-1:0]     data;
  } wb_t;

endpackage

@@ rtl/rvc_exec.sv @@
// ----------------------------------------------------------------------------
// rvc_exec
// decode and execute of one transaction against the current architectural state
// ----------------------------------------------------------------------------
module rvc_exec import rvc_pkg::*; (
  input  in_t             item,
  input  logic [XLEN-1:0] pc,
  input  logic [XLEN-1:0] opa,
  input  logic [XLEN-1:0] opb,
  input  pend_t           pend,
  output out_t            res,
  output wb_t             wb,
  output pend_t           pend_nxt,
  output logic [XLEN-1:0] pc_nxt,
  output logic            retire
);

  logic [31:0] w;
  logic [6:0]  op, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [5:0]  f6, shamt;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] a32, b32;

  assign w      = item.instr_word;
  assign op     = w[6:0];
  assign rd     = w[11:7];
  assign f3     = w[14:12];
  assign rs1    = w[19:15];
  assign rs2    = w[24:20];
  assign f7     = w[31:25];
  assign f6     = w[31:26];
  assign shamt  = w[25:20];
  assign imm_i  = {{52{w[31]}}, w[31:20]};
  assign imm_s  = {{52{w[31]}}, w[31:25], w[11:7]};
  assign imm_b  = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u  = {{32{w[31]}}, w[31:12], 12'h000};
  assign imm_j  = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign a32    = opa[31:0];
  assign b32    = opb[31:0];

  always_comb begin
    logic ill, trp, ret, we, taken;
    logic [2:0]      cause;
    logic [XLEN-1:0] tval, wv, npc, t, ld;
    logic [31:0]     r32;
    ill = 1'b0; trp = 1'b0; ret = 1'b1; we = 1'b0; taken = 1'b0;
    cause = CAUSE_ILLEGAL; tval = '0; wv = '0; npc = pc + 64'd4; t = '0; ld = '0;
    r32 = '0;
    res = '0;
    pend_nxt = pend;
    if (pend.access != MEM_NONE) begin
      ret = 1'b0;
      if ((pend.access == MEM_LOAD && item.action == ACT_LOAD_RSP) ||
          (pend.access == MEM_STORE && item.action == ACT_STORE_RSP)) begin
        pend_nxt.access = MEM_NONE;
        if (item.bus_fault) begin
          trp = 1'b1; cause = CAUSE_BUS_FAULT; tval = item.fault_value;
        end else begin
          ret = 1'b1;
          if (pend.access == MEM_LOAD) begin
            case (pend.size)
              2'd0: ld = pend.sgn ? {{56{item.load_data[7]}}, item.load_data[7:0]}
                                  : {56'd0, item.load_data[7:0]};
              2'd1: ld = pend.sgn ? {{48{item.load_data[15]}}, item.load_data[15:0]}
                                  : {48'd0, item.load_data[15:0]};
              2'd2: ld = pend.sgn ? {{32{item.load_data[31]}}, item.load_data[31:0]}
                                  : {32'd0, item.load_data[31:0]};
              default: ld = item.load_data;
            endcase
            we = 1'b1; wv = ld;
          end
        end
      end
    end else if (item.action == ACT_INSTR) begin
      if (pc[1:0] != 2'b00) begin
        trp = 1'b1; cause = CAUSE_MISALIGNED; tval = pc;
      end else begin
        case (op)
          OP_LUI: begin
            we = 1'b1; wv = imm_u;
          end
          OP_AUIPC: begin
            we = 1'b1; wv = pc + imm_u;
          end
          OP_MISC_MEM: ;
          OP_JAL, OP_JALR: begin
            if (op == OP_JALR && f3 != 3'd0) begin
              ill = 1'b1;
            end else begin
              t = (op == OP_JAL) ? pc + imm_j : ((opa + imm_i) & ~64'd1);
              if (t[1:0] != 2'b00) begin
                trp = 1'b1; cause = CAUSE_MISALIGNED; tval = t;
              end else begin
                we = 1'b1; wv = pc + 64'd4; npc = t;
              end
            end
          end
          OP_BRANCH: begin
            case (f3)
              3'd0: taken = opa == opb;
              3'd1: taken = opa != opb;
              3'd4: taken = $signed(opa) < $signed(opb);
              3'd5: taken = $signed(opa) >= $signed(opb);
              3'd6: taken = opa < opb;
              3'd7: taken = opa >= opb;
              default: ill = 1'b1;
            endcase
            if (!ill && taken) begin
              t = pc + imm_b;
              if (t[1:0] != 2'b00) begin
                trp = 1'b1; cause = CAUSE_MISALIGNED; tval = t;
              end else begin
                npc = t;
              end
            end
          end
          OP_LOAD: begin
            if (f3 == 3'd7) begin
              ill = 1'b1;
            end else begin
              ret = 1'b0;
              pend_nxt.access = MEM_LOAD;
              pend_nxt.dest   = rd;
              pend_nxt.size   = f3[1:0];
              pend_nxt.sgn    = (f3 < 3'd3);
              res.mem_op      = MEM_LOAD;
              res.mem_addr    = opa + imm_i;
              res.mem_size    = f3[1:0];
            end
          end
          OP_STORE: begin
            if (f3 > 3'd3) begin
              ill = 1'b1;
            end else begin
              ret = 1'b0;
              pend_nxt.access = MEM_STORE;
              res.mem_op      = MEM_STORE;
              res.mem_addr    = opa + imm_s;
              res.mem_size    = f3[1:0];
              res.store_value = opb;
            end
          end
          OP_IMM: begin
            we = 1'b1;
            case (f3)
              3'd0: wv = opa + imm_i;
              3'd1: begin
                if (f6 != 6'd0) ill = 1'b1;
                else wv = opa << shamt;
              end
              3'd2: wv = {63'd0, $signed(opa) < $signed(imm_i)};
              3'd3: wv = {63'd0, opa < imm_i};
              3'd4: wv = opa ^ imm_i;
              3'd5: begin
                if (f6 == 6'd0) wv = opa >> shamt;
                else if (f6 == F6_ALT) wv = $unsigned($signed(opa) >>> shamt);
                else ill = 1'b1;
              end
              3'd6: wv = opa | imm_i;
              default: wv = opa & imm_i;
            endcase
          end
          OP_IMM_W: begin
            we = 1'b1;
            if (f3 == 3'd0) r32 = a32 + imm_i[31:0];
            else if (f3 == 3'd1 && f7 == 7'd0) r32 = a32 << rs2;
            else if (f3 == 3'd5 && f7 == 7'd0) r32 = a32 >> rs2;
            else if (f3 == 3'd5 && f7 == F7_ALT) r32 = $unsigned($signed(a32) >>> rs2);
            else ill = 1'b1;
            wv = {{32{r32[31]}}, r32};
          end
          OP_REG: begin
            we = 1'b1;
            if (f7 != 7'd0 && f7 != F7_ALT) ill = 1'b1;
            else if (f7 == F7_ALT && f3 != 3'd0 && f3 != 3'd5) ill = 1'b1;
            case (f3)
              3'd0: wv = (f7 != 7'd0) ? opa - opb : opa + opb;
              3'd1: wv = opa << opb[5:0];
              3'd2: wv = {63'd0, $signed(opa) < $signed(opb)};
              3'd3: wv = {63'd0, opa < opb};
              3'd4: wv = opa ^ opb;
              3'd5: wv = (f7 != 7'd0) ? $unsigned($signed(opa) >>> opb[5:0])
                                      : opa >> opb[5:0];
              3'd6: wv = opa | opb;
              default: wv = opa & opb;
            endcase
          end
          OP_REG_32: begin
            we = 1'b1;
            if (f7 != 7'd0 && f7 != F7_ALT) ill = 1'b1;
            else if (f3 == 3'd0) r32 = (f7 != 7'd0) ? a32 - b32 : a32 + b32;
            else if (f3 == 3'd1 && f7 == 7'd0) r32 = a32 << opb[4:0];
            else if (f3 == 3'd5)
              r32 = (f7 != 7'd0) ? $unsigned($signed(a32) >>> opb[4:0]) : a32 >> opb[4:0];
            else ill = 1'b1;
            wv = {{32{r32[31]}}, r32};
          end
          OP_SYSTEM: begin
            if (f3 != 3'd0 || rd != 5'd0 || rs1 != 5'd0) ill = 1'b1;
            else if (w[31:20] == IMM_ECALL) begin
              trp = 1'b1; cause = CAUSE_ECALL; tval = '0;
            end else if (w[31:20] == IMM_EBREAK) begin
              trp = 1'b1; cause = CAUSE_BREAKPOINT; tval = pc;
            end else ill = 1'b1;
          end
          default: ill = 1'b1;
        endcase
      end
    end else begin
      ret = 1'b0;
      if (item.action == ACT_FETCH_FAULT) begin
        trp = 1'b1; cause = CAUSE_BUS_FAULT; tval = item.fault_value;
      end
    end
    if (ill) begin
      trp = 1'b1; cause = CAUSE_ILLEGAL; tval = {32'd0, w};
    end
    if (trp) begin
      ret = 1'b0; we = 1'b0;
      res.mem_op = MEM_NONE; res.mem_addr = '0; res.mem_size = '0; res.store_value = '0;
      pend_nxt.access = (pend.access != MEM_NONE) ? MEM_NONE : pend.access;
    end
    if (pend.access == MEM_NONE && item.action == ACT_INSTR && trp)
      pend_nxt = pend;
    retire         = ret;
    pc_nxt         = ret ? npc : pc;
    wb.we          = we && ret;
    wb.addr        = (pend.access != MEM_NONE) ? pend.dest : rd;
    wb.data        = wv;
    res.retired    = ret;
    res.trap       = trp;
    res.trap_cause = trp ? cause : 3'd0;
    res.trap_value = trp ? tval : '0;
    res.pc_now     = pc_nxt;
  end

endmodule

@@ rtl/rv64i_integer_core_unit.sv @@
// ----------------------------------------------------------------------------
// rv64i_integer_core_unit
// in-order rv64i core: register file in a synchronous ram, one transaction per step
// ----------------------------------------------------------------------------
// path: the ram read registers the operands and the transaction, then execute registers the result
// throughput: one transaction per cycle while out_ready does not stall the output; a write
// is forwarded to a read of the same register issued in the same cycle
// reset: rst_n synchronous; pc to RESET_ADDRESS, register valid bits cleared
module rv64i_integer_core_unit import rvc_pkg::*; #(
  parameter logic [XLEN-1:0] RESET_ADDRESS = DefaultResetAddress
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [XLEN-1:0] regs_mem [RegCount];
  logic [RegCount-1:0] reg_valid_r;

  logic            s1_valid_r, out_valid_r;
  in_t             s1_item_r;
  out_t            out_data_r;
  logic [XLEN-1:0] rd1_r, rd2_r, fdat1_r, fdat2_r;
  logic            v1_r, v2_r, f1_r, f2_r;
  logic [XLEN-1:0] pc_r, cnt_r;
  pend_t           pend_r;

  logic            adv, in_acc, fire, retire;
  logic [XLEN-1:0] opa, opb, pc_nxt;
  logic [RegAddrW-1:0] rs1, rs2;
  logic            hit1, hit2;
  out_t            res;
  wb_t             wb, wbq;
  pend_t           pend_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign fire     = s1_valid_r && adv;
  assign rs1      = in_data.instr_word[19:15];
  assign rs2      = in_data.instr_word[24:20];

  assign wbq.we   = wb.we && fire && (wb.addr != '0);
  assign wbq.addr = wb.addr;
  assign wbq.data = wb.data;

  assign hit1 = wbq.we && (wbq.addr == rs1);
  assign hit2 = wbq.we && (wbq.addr == rs2);

  assign opa = !v1_r ? '0 : (f1_r ? fdat1_r : rd1_r);
  assign opb = !v2_r ? '0 : (f2_r ? fdat2_r : rd2_r);

  rvc_exec u_exec (
    .item     (s1_item_r),
    .pc       (pc_r),
    .opa      (opa),
    .opb      (opb),
    .pend     (pend_r),
    .res      (res),
    .wb       (wb),
    .pend_nxt (pend_nxt),
    .pc_nxt   (pc_nxt),
    .retire   (retire)
  );

  always_ff @(posedge clk) begin
    if (wbq.we) begin
      regs_mem[wbq.addr] <= wbq.data;
    end
    if (in_acc) begin
      rd1_r <= regs_mem[rs1];
      rd2_r <= regs_mem[rs2];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
      fdat1_r   <= wbq.data;
      fdat2_r   <= wbq.data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reg_valid_r <= '0;
      pc_r        <= RESET_ADDRESS;
      cnt_r       <= '0;
      pend_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      f1_r        <= 1'b0;
      f2_r        <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        v1_r       <= hit1 || reg_valid_r[rs1];
        v2_r       <= hit2 || reg_valid_r[rs2];
        f1_r       <= hit1;
        f2_r       <= hit2;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (wbq.we) begin
        reg_valid_r[wbq.addr] <= 1'b1;
      end
      if (fire) begin
        pc_r   <= pc_nxt;
        pend_r <= pend_nxt;
        if (retire) begin
          cnt_r <= cnt_r + 64'd1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n) !reg_valid_r[0])
    else $error("x0 marked as written");
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a transaction in execute");
  assert property (@(posedge clk) disable iff (!rst_n) pend_r.access != 2'd3)
    else $error("bad pending access code");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.trap && out_data_r.retired))
    else $error("trap and retire together");

endmodule

@@ verif/rv64i_integer_core_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rv64i_integer_core_unit_tb
// drives instruction words and memory responses into the rv64i core, runs an
// architectural model of the core alongside it and compares every result
// transaction field by field, under several sender and receiver idle phases
// ----------------------------------------------------------------------------
module rv64i_integer_core_unit_tb;
  import rvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [XLEN-1:0] BootAddr = DefaultResetAddress;
  localparam int unsigned StallLimit = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  rv64i_integer_core_unit #(.RESET_ADDRESS(BootAddr)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic [XLEN-1:0] arch_x [RegCount];
  logic [XLEN-1:0] arch_pc;
  logic [1:0]      wait_access;
  logic [4:0]      wait_dest;
  logic [1:0]      wait_size;
  logic            wait_sgn;

  out_t expected_q[$];
  int   errors = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_recv;
  int   quiet_cycles = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic logic [XLEN-1:0] sext(logic [XLEN-1:0] v, int bits);
    logic [XLEN-1:0] m;
    m = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    v = v & m;
    if (bits < 64 && v[bits-1]) v = v | ~m;
    return v;
  endfunction

  function automatic logic [XLEN-1:0] rd_x(logic [4:0] i);
    return (i == 5'd0) ? '0 : arch_x[i];
  endfunction

  function automatic void wr_x(logic [4:0] i, logic [XLEN-1:0] v);
    if (i != 5'd0) arch_x[i] = v;
  endfunction

  function automatic logic [XLEN-1:0] sra(logic [XLEN-1:0] a, int s);
    return $signed(a) >>> s;
  endfunction

  function automatic void exec_instr(logic [31:0] w, ref out_t r);
    logic [6:0] op;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] f6;
    logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, a, b, v, t, pc;
    logic [31:0] a32, b32;
    bit bad, taken;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
    f7 = w[31:25]; f6 = w[31:26];
    imm_i = sext({52'd0, w[31:20]}, 12);
    imm_s = sext({52'd0, w[31:25], w[11:7]}, 12);
    imm_b = sext({51'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
    imm_u = sext({32'd0, w[31:12], 12'd0}, 32);
    imm_j = sext({43'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
    a = rd_x(rs1); b = rd_x(rs2); a32 = a[31:0]; b32 = b[31:0];
    pc = arch_pc; v = '0; bad = 0; taken = 0;
    case (op)
      OP_LUI:      wr_x(rd, imm_u);
      OP_AUIPC:    wr_x(rd, pc + imm_u);
      OP_MISC_MEM: ;
      OP_JAL, OP_JALR: begin
        if (op == OP_JALR && f3 != 3'd0) bad = 1;
        else begin
          t = (op == OP_JAL) ? pc + imm_j : ((a + imm_i) & ~64'd1);
          if (t[1:0] != 2'd0) begin
            r.trap = 1; r.trap_cause = CAUSE_MISALIGNED; r.trap_value = t;
          end else begin
            wr_x(rd, pc + 64'd4);
            arch_pc = t; r.retired = 1;
          end
          return;
        end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = ($signed(a) < $signed(b));
          3'd5: taken = ($signed(a) >= $signed(b));
          3'd6: taken = (a < b);
          3'd7: taken = (a >= b);
          default: bad = 1;
        endcase
        if (!bad && taken) begin
          t = pc + imm_b;
          if (t[1:0] != 2'd0) begin
            r.trap = 1; r.trap_cause = CAUSE_MISALIGNED; r.trap_value = t;
          end else begin
            arch_pc = t; r.retired = 1;
          end
          return;
        end
      end
      OP_LOAD: begin
        if (f3 == 3'd7) bad = 1;
        else begin
          wait_access = MEM_LOAD; wait_dest = rd; wait_size = f3[1:0];
          wait_sgn = (f3 < 3'd3);
          r.mem_op = MEM_LOAD; r.mem_addr = a + imm_i; r.mem_size = f3[1:0];
          return;
        end
      end
      OP_STORE: begin
        if (f3 > 3'd3) bad = 1;
        else begin
          wait_access = MEM_STORE;
          r.mem_op = MEM_STORE; r.mem_addr = a + imm_s; r.mem_size = f3[1:0];
          r.store_value = b;
          return;
        end
      end
      OP_IMM: begin
        case (f3)
          3'd0: v = a + imm_i;
          3'd1: if (f6 != 6'd0) bad = 1; else v = a << w[25:20];
          3'd2: v = {63'd0, $signed(a) < $signed(imm_i)};
          3'd3: v = {63'd0, a < imm_i};
          3'd4: v = a ^ imm_i;
          3'd5: begin
            if (f6 == 6'd0) v = a >> w[25:20];
            else if (f6 == F6_ALT) v = sra(a, w[25:20]);
            else bad = 1;
          end
          3'd6: v = a | imm_i;
          default: v = a & imm_i;
        endcase
        if (!bad) wr_x(rd, v);
      end
      OP_IMM_W: begin
        if (f3 == 3'd0) v = sext({32'd0, a32 + imm_i[31:0]}, 32);
        else if (f3 == 3'd1 && f7 == 7'd0) v = sext({32'd0, a32 << rs2}, 32);
        else if (f3 == 3'd5 && f7 == 7'd0) v = sext({32'd0, a32 >> rs2}, 32);
        else if (f3 == 3'd5 && f7 == F7_ALT)
          v = sext(sra(sext({32'd0, a32}, 32), rs2), 32);
        else bad = 1;
        if (!bad) wr_x(rd, v);
      end
      OP_REG: begin
        if (f7 != 7'd0 && f7 != F7_ALT) bad = 1;
        else if (f7 == F7_ALT && f3 != 3'd0 && f3 != 3'd5) bad = 1;
        else begin
          case (f3)
            3'd0: v = (f7 != 7'd0) ? a - b : a + b;
            3'd1: v = a << b[5:0];
            3'd2: v = {63'd0, $signed(a) < $signed(b)};
            3'd3: v = {63'd0, a < b};
            3'd4: v = a ^ b;
            3'd5: v = (f7 != 7'd0) ? sra(a, b[5:0]) : a >> b[5:0];
            3'd6: v = a | b;
            default: v = a & b;
          endcase
          wr_x(rd, v);
        end
      end
      OP_REG_32: begin
        if (f7 != 7'd0 && f7 != F7_ALT) bad = 1;
        else if (f3 == 3'd0)
          v = sext({32'd0, (f7 != 7'd0) ? a32 - b32 : a32 + b32}, 32);
        else if (f3 == 3'd1 && f7 == 7'd0) v = sext({32'd0, a32 << b[4:0]}, 32);
        else if (f3 == 3'd5)
          v = (f7 != 7'd0) ? sext(sra(sext({32'd0, a32}, 32), b[4:0]), 32)
                           : sext({32'd0, a32 >> b[4:0]}, 32);
        else bad = 1;
        if (!bad) wr_x(rd, v);
      end
      OP_SYSTEM: begin
        if (f3 != 3'd0 || rd != 5'd0 || rs1 != 5'd0) bad = 1;
        else if (w[31:20] == IMM_ECALL) begin
          r.trap = 1; r.trap_cause = CAUSE_ECALL; r.trap_value = '0; return;
        end else if (w[31:20] == IMM_EBREAK) begin
          r.trap = 1; r.trap_cause = CAUSE_BREAKPOINT; r.trap_value = pc; return;
        end else bad = 1;
      end
      default: bad = 1;
    endcase
    if (bad) begin
      r.trap = 1; r.trap_cause = CAUSE_ILLEGAL; r.trap_value = {32'd0, w};
      return;
    end
    arch_pc = pc + 64'd4; r.retired = 1;
  endfunction

  function automatic out_t core_step(in_t it);
    out_t r;
    int bits;
    logic [XLEN-1:0] d;
    r = '0;
    if (wait_access != MEM_NONE) begin
      if (wait_access == MEM_LOAD && it.action == ACT_LOAD_RSP) begin
        wait_access = MEM_NONE;
        if (it.bus_fault) begin
          r.trap = 1; r.trap_cause = CAUSE_BUS_FAULT; r.trap_value = it.fault_value;
        end else begin
          bits = 8 << wait_size;
          d = it.load_data;
          if (bits < 64) begin
            d = d & ((64'd1 << bits) - 64'd1);
            if (wait_sgn) d = sext(d, bits);
          end
          wr_x(wait_dest, d);
          arch_pc = arch_pc + 64'd4; r.retired = 1;
        end
      end else if (wait_access == MEM_STORE && it.action == ACT_STORE_RSP) begin
        wait_access = MEM_NONE;
        if (it.bus_fault) begin
          r.trap = 1; r.trap_cause = CAUSE_BUS_FAULT; r.trap_value = it.fault_value;
        end else begin
          arch_pc = arch_pc + 64'd4; r.retired = 1;
        end
      end
    end else if (it.action == ACT_INSTR) begin
      if (arch_pc[1:0] != 2'd0) begin
        r.trap = 1; r.trap_cause = CAUSE_MISALIGNED; r.trap_value = arch_pc;
      end else exec_instr(it.instr_word, r);
    end else if (it.action == ACT_FETCH_FAULT) begin
      r.trap = 1; r.trap_cause = CAUSE_BUS_FAULT; r.trap_value = it.fault_value;
    end
    r.pc_now = arch_pc;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [XLEN-1:0] got,
                                 logic [XLEN-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // drive one transaction and hold it until accepted
  task automatic send_item(in_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(core_step(it));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result transaction, pc %h", out_data.pc_now);
          errors++;
        end else begin
          out_t e;
          e = expected_q.pop_front();
          if (out_data.pc_now !== e.pc_now) report_mismatch("pc_now", out_data.pc_now, e.pc_now);
          if (out_data.mem_op !== e.mem_op) report_mismatch("mem_op", out_data.mem_op, e.mem_op);
          if (out_data.mem_addr !== e.mem_addr)
            report_mismatch("mem_addr", out_data.mem_addr, e.mem_addr);
          if (out_data.mem_size !== e.mem_size)
            report_mismatch("mem_size", out_data.mem_size, e.mem_size);
          if (out_data.store_value !== e.store_value)
            report_mismatch("store_value", out_data.store_value, e.store_value);
          if (out_data.retired !== e.retired)
            report_mismatch("retired", out_data.retired, e.retired);
          if (out_data.trap !== e.trap) report_mismatch("trap", out_data.trap, e.trap);
          if (out_data.trap_cause !== e.trap_cause)
            report_mismatch("trap_cause", out_data.trap_cause, e.trap_cause);
          if (out_data.trap_value !== e.trap_value)
            report_mismatch("trap_value", out_data.trap_value, e.trap_value);
        end
      end
      out_ready <= !hold_recv &&
                   !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [XLEN-1:0] rand64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic in_t make_instr(logic [31:0] w);
    in_t it;
    it = '0;
    it.action = ACT_INSTR; it.instr_word = w;
    it.load_data = rand64(); it.fault_value = rand64();
    it.bus_fault = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_t make_rsp(logic [1:0] act, bit fault);
    in_t it;
    it = '0;
    it.action = act; it.load_data = rand64(); it.bus_fault = fault;
    it.fault_value = rand64(); it.instr_word = $urandom();
    return it;
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
  endfunction

  // mostly well formed instructions with small register numbers
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [6:0] op;
    int k;
    w = $urandom();
    w[11:7] = pick_reg(); w[19:15] = pick_reg(); w[24:20] = pick_reg();
    k = $urandom_range(99);
    if (k < 5) return w;
    case ($urandom_range(12))
      0: op = OP_LUI;  1: op = OP_AUIPC; 2: op = OP_MISC_MEM; 3: op = OP_JAL;
      4: op = OP_JALR; 5: op = OP_BRANCH; 6: op = OP_LOAD; 7: op = OP_STORE;
      8: op = OP_IMM;  9: op = OP_IMM_W; 10: op = OP_REG; 11: op = OP_REG_32;
      default: op = OP_SYSTEM;
    endcase
    w[6:0] = op;
    if (k < 85) begin
      if (op == OP_JALR) w[14:12] = 3'd0;
      if (op == OP_REG || op == OP_REG_32 || op == OP_IMM_W)
        w[31:25] = $urandom_range(1) ? F7_ALT : 7'd0;
      if (op == OP_IMM && (w[14:12] == 3'd1 || w[14:12] == 3'd5))
        w[31:26] = $urandom_range(1) ? {F6_ALT} : 6'd0;
      if (op == OP_SYSTEM) begin
        w[19:7] = '0; w[31:20] = $urandom_range(1) ? IMM_EBREAK : IMM_ECALL;
      end
      if ((op == OP_JAL || op == OP_BRANCH) && $urandom_range(3) != 0) begin
        w[8] = 1'b0; w[21] = 1'b0;
      end
    end
    return w;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(int n);
    in_t it;
    for (int i = 0; i < n; i++) begin
      if (wait_access != MEM_NONE) begin
        if ($urandom_range(9) == 0) send_item(make_instr($urandom()));
        it = make_rsp(wait_access == MEM_LOAD ? ACT_LOAD_RSP : ACT_STORE_RSP,
                      $urandom_range(7) == 0);
        send_item(it);
      end else if ($urandom_range(29) == 0) begin
        send_item(make_rsp(2'($urandom_range(1, 3)), 1'($urandom_range(1))));
      end else begin
        send_item(make_instr(rand_instr()));
      end
    end
  endtask

  task automatic test_directed();
    logic [31:0] w;
    // x1 = -1, x2 = min, loads of all sizes, a doubleword store
    send_item(make_instr({20'hfffff, 5'd1, OP_LUI}));
    send_item(make_instr({12'hfff, 5'd1, 3'd6, 5'd1, OP_IMM}));
    send_item(make_instr({12'h001, 5'd0, 3'd0, 5'd2, OP_IMM}));
    send_item(make_instr({6'd0, 6'd63, 5'd2, 3'd1, 5'd2, OP_IMM}));
    send_item(make_instr({7'd0, 5'd1, 5'd2, 3'd0, 5'd3, OP_REG}));
    send_item(make_instr({F7_ALT, 5'd1, 5'd2, 3'd5, 5'd4, OP_REG_32}));
    for (int s = 0; s < 7; s++) begin
      send_item(make_instr({12'h7ff, 5'd1, 3'(s), 5'd5, OP_LOAD}));
      send_item(make_rsp(ACT_LOAD_RSP, 1'b0));
    end
    send_item(make_instr({7'h3f, 5'd1, 5'd2, 3'd3, 5'h1f, OP_STORE}));
    send_item(make_instr({32'd0}));
    send_item(make_rsp(ACT_LOAD_RSP, 1'b0));
    send_item(make_rsp(ACT_STORE_RSP, 1'b1));
    send_item(make_rsp(ACT_STORE_RSP, 1'b0));
    send_item(make_rsp(ACT_FETCH_FAULT, 1'b1));
    send_item(make_instr({12'h000, 13'd0, OP_SYSTEM}));
    send_item(make_instr({12'h001, 13'd0, OP_SYSTEM}));
    send_item(make_instr({12'h002, 13'd0, OP_SYSTEM}));
    // misaligned jal, then jalr to an odd target that rounds down to misaligned
    w = {1'b0, 10'd1, 1'b0, 8'd0, 5'd6, OP_JAL};
    send_item(make_instr(w));
    send_item(make_instr({12'h003, 5'd0, 3'd0, 5'd7, OP_JALR}));
    send_item(make_instr({7'd0, 5'd0, 5'd0, 3'd2, 5'd0, OP_BRANCH}));
    drain();
  endtask

  task automatic test_phase(int s_pct, int r_pct, int n);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    run_random(n);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      run_random(60);
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 0;
    for (int i = 0; i < RegCount; i++) arch_x[i] = '0;
    arch_pc = BootAddr;
    wait_access = MEM_NONE; wait_dest = '0; wait_size = '0; wait_sgn = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_phase(0, 0, 400);
    drain();
    test_phase(64, 0, 350);
    test_phase(0, 64, 350);
    test_phase(34, 34, 350);
    test_backpressure();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
